/* rtl/lik_pkg.sv */
package lik_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TAB_LEN = 24;
    localparam int SQRT_STEPS = 16;
    localparam int COORD_W = 16;
    localparam int LEN_W = 15;
    localparam int SERVO_W = 14;
    localparam int SQ_W = 32;
    localparam int CX_W = 46;
    localparam int ANG_W = 26;
    localparam int SCALE_SHIFT = 24;
    localparam int DEG_ONE = 16384;
    localparam int MIN_REACH_EFF = 16;
    localparam int REACH_MARGIN = 2;

    localparam logic [1:0] REG_HIP_LENGTH = 2'd0;
    localparam logic [1:0] REG_FEMUR_LENGTH = 2'd1;
    localparam logic [1:0] REG_ANGLE_FLOOR = 2'd2;
    localparam logic [1:0] REG_ANGLE_CEILING = 2'd3;

    localparam int ATAN_TAB [ATAN_TAB_LEN] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0
    };

    typedef struct packed {
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } cordic_t;

    // Quadrant fold and scaling ahead of the first rotation.
    function automatic cordic_t cordic_pre(logic signed [17:0] y, logic signed [17:0] x);
        cordic_t c;
        logic signed [17:0] xf;
        logic signed [17:0] yf;
        c.zero = (x == 18'sd0) && (y == 18'sd0);
        c.ang = '0;
        xf = x;
        yf = y;
        if (x < 0)
        begin
            c.ang = (y >= 0) ? ANG_W'(180 * DEG_ONE) : ANG_W'(-180 * DEG_ONE);
            xf = -x;
            yf = -y;
        end
        c.x = CX_W'(xf) <<< SCALE_SHIFT;
        c.y = CX_W'(yf) <<< SCALE_SHIFT;
        return c;
    endfunction

    // Round half up to 1/64 degree, then raise to the floor and lower to the ceiling.
    function automatic logic [SERVO_W-1:0] to_servo(logic signed [ANG_W-1:0] a,
                                                    logic [SERVO_W-1:0] lo,
                                                    logic [SERVO_W-1:0] hi);
        logic signed [ANG_W:0]   t;
        logic signed [ANG_W-8:0] v;
        logic signed [ANG_W-8:0] lo_s;
        logic signed [ANG_W-8:0] hi_s;
        t = {a[ANG_W-1], a} + (ANG_W+1)'(128);
        v = t[ANG_W:8];
        lo_s = $signed((ANG_W-7)'(lo));
        hi_s = $signed((ANG_W-7)'(hi));
        if (v < lo_s)
        begin
            v = lo_s;
        end
        if (v > hi_s)
        begin
            v = hi_s;
        end
        return v[SERVO_W-1:0];
    endfunction

endpackage

/* rtl/lik_sqrt_cell.sv */
module lik_sqrt_cell
    import lik_pkg::*;
#(
    parameter int STEP = 0,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   n_in,
    input  logic [SQ_W-1:0]   res_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [SQ_W-1:0]   n_out,
    output logic [SQ_W-1:0]   res_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (SQ_W - 2 - 2 * STEP);

    logic [SQ_W-1:0]   n_reg;
    logic [SQ_W-1:0]   n_next;
    logic [SQ_W-1:0]   res_reg;
    logic [SQ_W-1:0]   res_next;
    logic [SIDE_W-1:0] side_reg;
    logic [SQ_W:0]     trial;
    logic [SQ_W:0]     res_half;

    always_comb
    begin
        trial = {1'b0, res_in} + BIT;
        res_half = {2'b0, res_in[SQ_W-1:1]};
        if ({1'b0, n_in} >= trial)
        begin
            n_next = n_in - trial[SQ_W-1:0];
            res_next = SQ_W'(res_half + BIT);
        end
        else
        begin
            n_next = n_in;
            res_next = res_half[SQ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            res_reg <= res_next;
            side_reg <= side_in;
        end
    end

    assign n_out = n_reg;
    assign res_out = res_reg;
    assign side_out = side_reg;

endmodule

/* rtl/lik_cordic_cell.sv */
module lik_cordic_cell
    import lik_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  cordic_t c_in,
    output cordic_t c_out
);

    cordic_t c_reg;
    cordic_t c_next;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;

    always_comb
    begin
        xs = c_in.x;
        ys = c_in.y;
        dx = ys >>> STEP;
        dy = xs >>> STEP;
        c_next = c_in;
        if (!ys[CX_W-1])
        begin
            c_next.x = xs + dx;
            c_next.y = ys - dy;
            c_next.ang = c_in.ang + ANG_W'(ATAN_TAB[STEP]);
        end
        else
        begin
            c_next.x = xs - dx;
            c_next.y = ys + dy;
            c_next.ang = c_in.ang - ANG_W'(ATAN_TAB[STEP]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

/* rtl/leg_inverse_kinematics.sv */
// Throughput: one transaction per cycle; three 16-step square-root cell chains and
// three CORDIC_STAGES-long rotation chains run as one pipeline that stalls only
// while the output holds an untaken result.
// Reset: rst_n is asynchronous; it empties the pipeline and restores the register defaults.
module leg_inverse_kinematics
    import lik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // target_x, target_y, target_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // hip_angle, femur_angle, zero fill
    output logic        m_tuser,   // reachable
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int P_REFF = SQRT_STEPS + 1;
    localparam int P_CLAMP = 2 * SQRT_STEPS + 3;
    localparam int LAT = 3 * SQRT_STEPS + 8 + CORDIC_STAGES;
    localparam int SIDE_A = 3 * COORD_W;
    localparam int SIDE_B = 4 * COORD_W;
    localparam int SIDE_C = 5 * COORD_W + 1;

    logic en;
    logic [LAT-1:0] vld_reg;

    logic [LEN_W-1:0]   hip_len_reg;
    logic [LEN_W-1:0]   femur_len_reg;
    logic [SERVO_W-1:0] floor_reg;
    logic [SERVO_W-1:0] ceil_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hip_len_reg <= LEN_W'(320);
            femur_len_reg <= LEN_W'(640);
            floor_reg <= SERVO_W'(640);
            ceil_reg <= SERVO_W'(10880);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HIP_LENGTH:    hip_len_reg <= cfg_data;
                REG_FEMUR_LENGTH:  femur_len_reg <= cfg_data;
                REG_ANGLE_FLOOR:   floor_reg <= cfg_data[SERVO_W-1:0];
                REG_ANGLE_CEILING: ceil_reg <= cfg_data[SERVO_W-1:0];
                default: ;
            endcase
        end
    end

    assign en = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Planar radius squared.
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [2*COORD_W-1:0] sq_x;
    logic signed [2*COORD_W-1:0] sq_y;
    logic [SQ_W-1:0]   n1_reg;
    logic [SIDE_A-1:0] side1_reg;

    assign in_x = s_tdata[15:0];
    assign in_y = s_tdata[31:16];
    assign sq_x = in_x * in_x;
    assign sq_y = in_y * in_y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg <= SQ_W'(sq_x) + SQ_W'(sq_y);
            side1_reg <= s_tdata;
        end
    end

    logic [SQ_W-1:0]   na [0:SQRT_STEPS];
    logic [SQ_W-1:0]   ra [0:SQRT_STEPS];
    logic [SIDE_A-1:0] sa [0:SQRT_STEPS];
    assign na[0] = n1_reg;
    assign ra[0] = '0;
    assign sa[0] = side1_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt_a
        lik_sqrt_cell #(.STEP(k), .SIDE_W(SIDE_A)) u_cell (
            .clk(clk), .en(en),
            .n_in(na[k]), .res_in(ra[k]), .side_in(sa[k]),
            .n_out(na[k+1]), .res_out(ra[k+1]), .side_out(sa[k+1])
        );
    end

    // Effective reach past the hip offset.
    logic [COORD_W-1:0] reff_reg;
    logic [SIDE_A-1:0]  side2_reg;
    logic signed [COORD_W+1:0] reff_diff;

    assign reff_diff = $signed({2'b0, ra[SQRT_STEPS][COORD_W-1:0]})
                     - $signed({3'b0, hip_len_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            reff_reg <= (reff_diff < (COORD_W+2)'(MIN_REACH_EFF)) ? COORD_W'(MIN_REACH_EFF)
                                                                  : reff_diff[COORD_W-1:0];
            side2_reg <= sa[SQRT_STEPS];
        end
    end

    logic signed [COORD_W-1:0] z2;
    logic signed [2*COORD_W-1:0] sq_z2;
    logic [SQ_W-1:0]   n2_reg;
    logic [SIDE_B-1:0] side3_reg;

    assign z2 = side2_reg[47:32];
    assign sq_z2 = z2 * z2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg <= SQ_W'(reff_reg * reff_reg) + SQ_W'(sq_z2);
            side3_reg <= {reff_reg, side2_reg};
        end
    end

    logic [SQ_W-1:0]   nb [0:SQRT_STEPS];
    logic [SQ_W-1:0]   rb [0:SQRT_STEPS];
    logic [SIDE_B-1:0] sb [0:SQRT_STEPS];
    assign nb[0] = n2_reg;
    assign rb[0] = '0;
    assign sb[0] = side3_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt_b
        lik_sqrt_cell #(.STEP(k), .SIDE_W(SIDE_B)) u_cell (
            .clk(clk), .en(en),
            .n_in(nb[k]), .res_in(rb[k]), .side_in(sb[k]),
            .n_out(nb[k+1]), .res_out(rb[k+1]), .side_out(sb[k+1])
        );
    end

    // Reach clamp.
    logic [COORD_W-1:0] two_l;
    logic [COORD_W-1:0] d_raw;
    logic [COORD_W-1:0] d_reg;
    logic               reach_reg;
    logic [SIDE_B-1:0]  side4_reg;

    assign two_l = {femur_len_reg, 1'b0};
    assign d_raw = rb[SQRT_STEPS][COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d_raw > two_l)
            begin
                d_reg <= (two_l >= COORD_W'(REACH_MARGIN)) ? two_l - COORD_W'(REACH_MARGIN)
                                                           : '0;
                reach_reg <= 1'b0;
            end
            else
            begin
                d_reg <= d_raw;
                reach_reg <= 1'b1;
            end
            side4_reg <= sb[SQRT_STEPS];
        end
    end

    logic [SQ_W-1:0]   n3_reg;
    logic [SIDE_C-1:0] side5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n3_reg <= SQ_W'(two_l * two_l) - SQ_W'(d_reg * d_reg);
            side5_reg <= {reach_reg, d_reg, side4_reg};
        end
    end

    logic [SQ_W-1:0]   nc [0:SQRT_STEPS];
    logic [SQ_W-1:0]   rc [0:SQRT_STEPS];
    logic [SIDE_C-1:0] sc [0:SQRT_STEPS];
    assign nc[0] = n3_reg;
    assign rc[0] = '0;
    assign sc[0] = side5_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt_c
        lik_sqrt_cell #(.STEP(k), .SIDE_W(SIDE_C)) u_cell (
            .clk(clk), .en(en),
            .n_in(nc[k]), .res_in(rc[k]), .side_in(sc[k]),
            .n_out(nc[k+1]), .res_out(rc[k+1]), .side_out(sc[k+1])
        );
    end

    // Three angle chains: hip, elevation of the foot, and the knee half-angle.
    logic [SIDE_C-1:0] sce;
    cordic_t hc [0:CORDIC_STAGES];
    cordic_t zc [0:CORDIC_STAGES];
    cordic_t kc [0:CORDIC_STAGES];
    logic reach_dly_reg [0:CORDIC_STAGES];

    assign sce = sc[SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hc[0] <= cordic_pre(18'(signed'(sce[31:16])), 18'(signed'(sce[15:0])));
            zc[0] <= cordic_pre(18'(signed'(sce[47:32])), 18'(sce[63:48]));
            kc[0] <= cordic_pre(18'(rc[SQRT_STEPS][COORD_W-1:0]), 18'(sce[79:64]));
            reach_dly_reg[0] <= sce[80];
            for (int k = 1; k <= CORDIC_STAGES; k++)
            begin
                reach_dly_reg[k] <= reach_dly_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        lik_cordic_cell #(.STEP(k)) u_hip (.clk(clk), .en(en), .c_in(hc[k]), .c_out(hc[k+1]));
        lik_cordic_cell #(.STEP(k)) u_elv (.clk(clk), .en(en), .c_in(zc[k]), .c_out(zc[k+1]));
        lik_cordic_cell #(.STEP(k)) u_knee (.clk(clk), .en(en), .c_in(kc[k]), .c_out(kc[k+1]));
    end

    logic signed [ANG_W-1:0] hip_sum_reg;
    logic signed [ANG_W-1:0] femur_sum_reg;
    logic                    reach_sum_reg;
    logic signed [ANG_W-1:0] a_hip;
    logic signed [ANG_W-1:0] a_elv;
    logic signed [ANG_W-1:0] a_knee;

    assign a_hip = hc[CORDIC_STAGES].zero ? '0 : hc[CORDIC_STAGES].ang;
    assign a_elv = zc[CORDIC_STAGES].zero ? '0 : zc[CORDIC_STAGES].ang;
    assign a_knee = kc[CORDIC_STAGES].zero ? '0 : kc[CORDIC_STAGES].ang;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hip_sum_reg <= a_hip + ANG_W'(90 * DEG_ONE);
            femur_sum_reg <= a_elv + a_knee;
            reach_sum_reg <= reach_dly_reg[CORDIC_STAGES];
        end
    end

    logic [SERVO_W-1:0] hip_out_reg;
    logic [SERVO_W-1:0] femur_out_reg;
    logic               reach_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hip_out_reg <= to_servo(hip_sum_reg, floor_reg, ceil_reg);
            femur_out_reg <= to_servo(femur_sum_reg, floor_reg, ceil_reg);
            reach_out_reg <= reach_sum_reg;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata = {4'b0, femur_out_reg, hip_out_reg};
    assign m_tuser = reach_out_reg;

    a_angles_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (floor_reg <= ceil_reg) |->
            hip_out_reg >= floor_reg && hip_out_reg <= ceil_reg &&
            femur_out_reg >= floor_reg && femur_out_reg <= ceil_reg)
        else $error("servo angle outside the configured limits");

    a_reff_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_REFF] |-> reff_reg >= COORD_W'(MIN_REACH_EFF))
        else $error("effective reach below its floor");

    a_d_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_CLAMP] |-> d_reg <= two_l)
        else $error("distance exceeds twice the femur length after clamp");

endmodule
